>>> hw/rtl/lmfb_pkg.sv
// Shared types, constants and helpers for the LED matrix frame buffer.
`default_nettype none

package lmfb_pkg;

	localparam int ROWS   = 8;
	localparam int COLS   = 8;
	localparam int BYTE_W = 8;
	localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [3:0] KIND_SET_PIXEL = 4'd0;
	localparam logic [3:0] KIND_TOGGLE    = 4'd1;
	localparam logic [3:0] KIND_SET_ROW   = 4'd2;
	localparam logic [3:0] KIND_SET_COL   = 4'd3;
	localparam logic [3:0] KIND_VSPAN     = 4'd4;
	localparam logic [3:0] KIND_HSPAN     = 4'd5;
	localparam logic [3:0] KIND_REFRESH   = 4'd6;
	localparam logic [3:0] KIND_CLEAR     = 4'd7;
	localparam logic [3:0] KIND_INTENSITY = 4'd8;

	localparam logic [3:0] INTENSITY_REG = 4'd10;
	localparam logic [3:0] LEVEL_MAX     = 4'd15;

	typedef struct packed {
		logic [3:0]        kind;
		logic [3:0]        col;
		logic [3:0]        row;
		logic [3:0]        span_start;
		logic [3:0]        span_end;
		logic [7:0]        pixel_data;
		logic signed [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [3:0] reg_addr;
		logic [7:0] reg_data;
		logic       last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit;
	} lmfb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush_req;
		logic dirty_any;
		logic slot_free;
	} lmfb_stat_t;

	// bit of a row byte that holds column c
	function automatic logic [BYTE_W-1:0] col_bit(input logic [2:0] c, input logic mirror);
		logic [BYTE_W-1:0] m;
		m = mirror ? (8'h01 << c) : (8'h80 >> c);
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lmfb_ctrl.sv
// Sequencer for the frame buffer: command intake and dirty row scan.
`default_nettype none

module lmfb_ctrl
	import lmfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire lmfb_stat_t stat,
	output lmfb_cmd_t       cmd
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && stat.slot_free;

	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.emit   = (state_q == ST_SCAN) && stat.dirty_any && stat.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && stat.flush_req) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// done once the mask is empty
					if (!stat.dirty_any) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !in_ready)
		else $error("input taken during row scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !stat.dirty_any) |=> (state_q == ST_IDLE))
		else $error("scan did not finish on empty mask");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.accept)
		else $error("emit and accept in one cycle");

endmodule

`default_nettype wire

>>> hw/rtl/lmfb_dp.sv
// Datapath: pixel rows, dirty mask, orientation register and output register.
`default_nettype none

module lmfb_dp
	import lmfb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_data,
	input  wire in_item_t  in_data,
	input  wire lmfb_cmd_t cmd,
	output lmfb_stat_t     stat,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	logic [BYTE_W-1:0] rows_q [ROWS];
	logic [ROWS-1:0]   dirty_q;
	logic              mirror_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              col_ok, row_ok, on;
	logic [BYTE_W-1:0] cmask, hmask;
	logic [BYTE_W-1:0] row_nxt [ROWS];
	logic [ROWS-1:0]   row_we;
	logic [ROWS-1:0]   pick_oh;
	logic [ROW_IW-1:0] pick_idx;
	logic [BYTE_W-1:0] pick_data;
	logic [3:0]        lvl;
	logic              slot_free;

	assign col_ok = in_data.col < 4'(COLS);
	assign row_ok = in_data.row < 4'(ROWS);
	assign on     = in_data.pixel_data != '0;
	assign cmask  = col_bit(in_data.col[2:0], mirror_q);

	always_comb begin
		hmask = '0;
		for (int j = 0; j < COLS; j++) begin
			if (4'(j) >= in_data.span_start && 4'(j) < in_data.span_end) begin
				hmask = hmask | col_bit(3'(j), mirror_q);
			end
		end
	end

	// per-row next value and write enable for the command at the input
	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			logic hit;
			hit        = in_data.row == 4'(i);
			row_we[i]  = 1'b0;
			row_nxt[i] = rows_q[i];
			unique case (in_data.kind)
				KIND_SET_PIXEL: begin
					row_we[i]  = col_ok && row_ok && hit;
					row_nxt[i] = on ? (rows_q[i] | cmask) : (rows_q[i] & ~cmask);
				end
				KIND_TOGGLE: begin
					row_we[i]  = col_ok && row_ok && hit;
					row_nxt[i] = rows_q[i] ^ cmask;
				end
				KIND_SET_ROW: begin
					row_we[i]  = row_ok && hit;
					row_nxt[i] = in_data.pixel_data;
				end
				KIND_SET_COL: begin
					row_we[i]  = col_ok;
					row_nxt[i] = on ? (rows_q[i] | cmask) : (rows_q[i] & ~cmask);
				end
				KIND_VSPAN: begin
					row_we[i]  = col_ok && (4'(i) >= in_data.span_start)
						&& (4'(i) < in_data.span_end);
					row_nxt[i] = on ? (rows_q[i] | cmask) : (rows_q[i] & ~cmask);
				end
				KIND_HSPAN: begin
					// row is marked only when the span covers an on-screen column
					row_we[i]  = row_ok && hit && (hmask != '0);
					row_nxt[i] = on ? (rows_q[i] | hmask) : (rows_q[i] & ~hmask);
				end
				KIND_CLEAR: begin
					row_we[i]  = 1'b1;
					row_nxt[i] = '0;
				end
				default: begin
					row_we[i]  = 1'b0;
					row_nxt[i] = rows_q[i];
				end
			endcase
		end
	end

	// lowest dirty row goes out first
	always_comb begin
		pick_oh   = '0;
		pick_idx  = '0;
		pick_data = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (dirty_q[i]) begin
				pick_oh   = ROWS'(1) << i;
				pick_idx  = ROW_IW'(i);
				pick_data = rows_q[i];
			end
		end
	end

	always_comb begin
		if (in_data.level[7]) begin
			lvl = '0;
		end else if (in_data.level[6:4] != '0) begin
			lvl = LEVEL_MAX;
		end else begin
			lvl = in_data.level[3:0];
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				rows_q[i] <= '0;
			end
			dirty_q     <= '1;
			mirror_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mirror_q <= cfg_data;
			end
			if (cmd.accept) begin
				for (int i = 0; i < ROWS; i++) begin
					if (row_we[i]) begin
						rows_q[i] <= row_nxt[i];
					end
				end
				dirty_q <= dirty_q | row_we;
			end else if (cmd.emit) begin
				dirty_q <= dirty_q & ~pick_oh;
			end
			if (cmd.emit || (cmd.accept && in_data.kind == KIND_INTENSITY)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload only
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.reg_addr <= 4'(pick_idx) + 4'd1;
			out_q.reg_data <= pick_data;
			out_q.last     <= (dirty_q & ~pick_oh) == '0;
		end else if (cmd.accept && in_data.kind == KIND_INTENSITY) begin
			out_q.reg_addr <= INTENSITY_REG;
			out_q.reg_data <= {4'd0, lvl};
			out_q.last     <= 1'b1;
		end
	end

	always_comb begin
		stat.flush_req = (in_data.kind == KIND_REFRESH) || (in_data.kind == KIND_CLEAR);
		stat.dirty_any = dirty_q != '0;
		stat.slot_free = slot_free;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/led_matrix_frame_buffer.sv
// Top level of the 8x8 LED matrix frame buffer.
`default_nettype none

// 8x8 frame buffer that turns drawing commands into LED driver register
// writes. Drawing transactions (set/toggle pixel, set row, set column,
// vertical and horizontal spans) update the buffer and mark
// the touched rows dirty; they produce no output. Refresh sends one
// (row+1, row byte) write per dirty row in ascending order, flags the final
// one with last, and leaves the mask clear; refresh with a clean mask sends
// nothing. Clear zeroes the buffer and sends all 8 rows. Intensity sends a
// single write to register 10 with the level clamped to 0..15. Column bit
// order follows mirror_columns (cfg_we/cfg_data): 0 puts column 0 on bit 7,
// 1 puts it on bit 0. Refresh and clear enter the scan state, emit the
// dirty rows, and return to idle once the mask is empty. The scan
// walks the dirty mask one row per cycle into a single output register,
// so downstream stalls hold it. Input is taken whenever the scan is idle
// and the output register is free or being drained.
module led_matrix_frame_buffer
	import lmfb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_data,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	lmfb_cmd_t  cmd;
	lmfb_stat_t stat;

	lmfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lmfb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a row write only leaves when the output slot can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (stat.slot_free && stat.dirty_any))
		else $error("row write without room or without dirty row");

	// a row write shows up at the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid && out_data.reg_addr != INTENSITY_REG))
		else $error("row write lost");

	// intensity transaction gives one final write to the intensity register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && in_data.kind == KIND_INTENSITY)
		|=> (out_valid && out_data.last && out_data.reg_addr == INTENSITY_REG
			&& out_data.reg_data[7:4] == 4'd0))
		else $error("bad intensity write");

	// the last row write of a scan empties the mask
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit ##1 (out_valid && out_data.last)) |-> !stat.dirty_any)
		else $error("last flag with rows still dirty");

endmodule

`default_nettype wire
